[hdl/assert_macros.svh]
// Concurrent check helpers. Users need clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property check, sampled on clk, masked while in reset.
`define ASSERT_CHK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Condition that must never be seen.
`define ASSERT_NEVER(lbl, expr) `ASSERT_CHK(lbl, !(expr))

`else

`define ASSERT_CHK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)

`endif

`endif

[hdl/atp_pkg.sv]
`default_nettype none

package atp_pkg;

    // Build-time settings
    localparam int unsigned COMMAND_COUNT   = 9;
    localparam int unsigned FRACTION_DIGITS = 5;

    // Character codes
    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_NINE  = 8'h39;
    localparam logic [7:0] POINT_CHAR  = 8'h2E;
    localparam logic [7:0] START_RESET = 8'h24;
    localparam logic [7:0] DELIM_RESET = 8'h2C;
    localparam logic [7:0] STOP_RESET  = 8'h23;

    // Config register indexes
    localparam int unsigned REG_INDEX_W = 2;
    localparam logic [REG_INDEX_W-1:0] REG_START = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_DELIM = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_STOP  = 2'd2;

    // Command codes
    localparam logic [3:0] CMD_SET_FIRST = 4'd0;
    localparam logic [3:0] CMD_SET_LAST  = 4'd3;
    localparam logic [3:0] CMD_CLR_FIRST = 4'd4;
    localparam logic [3:0] CMD_CLR_LAST  = 4'd7;
    localparam logic [3:0] CMD_STOP_ALL  = 4'd8;

    function automatic longint unsigned pow10(input int unsigned n);
        longint unsigned p;
        p = 1;
        for (int unsigned i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    // Fraction is kept left-aligned to FRACTION_DIGITS decimal places
    localparam longint unsigned FRAC_DEN = pow10(FRACTION_DIGITS);
    localparam int unsigned FRAC_W  = $clog2(FRAC_DEN);
    localparam int unsigned CNT_W   = $clog2(FRACTION_DIGITS + 1);
    localparam int unsigned IDX_W   = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
    // Rounding numerator frac * 2^16 + den/2
    localparam int unsigned NUM_W   = FRAC_W + 16;
    // Reciprocal floor(2^NUM_W / den)
    localparam int unsigned RECIP_W = NUM_W - FRAC_W + 1;
    localparam int unsigned QW      = 17;
    localparam int unsigned PW      = QW + FRAC_W;

    localparam logic [NUM_W-1:0]   HALF_DEN = NUM_W'(FRAC_DEN / 2);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << NUM_W) / FRAC_DEN);
    localparam logic [FRAC_W-1:0]  DEN      = FRAC_W'(FRAC_DEN);

    typedef logic [FRACTION_DIGITS-1:0][FRAC_W-1:0] place_tab_t;

    function automatic place_tab_t place_table();
        place_tab_t      t;
        longint unsigned w;
        w = FRAC_DEN;
        for (int unsigned k = 0; k < FRACTION_DIGITS; k++)
        begin
            w = w / 10;
            t[k] = FRAC_W'(w);
        end
        return t;
    endfunction

    // Weight of the k-th fraction digit
    localparam place_tab_t PLACE_WEIGHT = place_table();

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  command_index;
        logic [31:0] parsed_data;
        logic [31:0] current_ch0;
        logic [31:0] current_ch1;
        logic [31:0] current_ch2;
        logic [31:0] current_ch3;
        logic        all_stopped;
    } out_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] delimiter_char;
        logic [7:0] stop_char;
    } cfg_t;

    // Summary of a message, valid on its last byte
    typedef struct packed {
        logic              ok;
        logic [3:0]        cmd;
        logic [15:0]       ipart;
        logic [FRAC_W-1:0] fpart;
    } msg_t;

endpackage

`default_nettype wire

[hdl/ascii_telecommand_parser.sv]
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       in_data   (rx_byte, end_of_message)
// out       output     out_valid / out_ready     out_data  (status, data, setpoints)
// cfg       input      cfg_write                 cfg_index, cfg_wdata
//
// One byte request is taken per cycle while in_ready is high; the parse state updates in the same cycle.
// The final byte of a message yields one result through 4 pipe stages
// (capture, scale, reciprocal multiply, check multiply), with the
// quotient correction feeding the output register.
// Stages only hold while the stage ahead is full, so bytes keep flowing while a
// result waits at the output; in_ready drops only once the pipe is backed up.
// rst_n (async, active low) returns chars to $ , #, clears parse state,
// setpoints and the stopped flag.
`default_nettype none

`include "assert_macros.svh"

module ascii_telecommand_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  atp_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output atp_pkg::out_t                      out_data,
    input  logic                               cfg_write,
    input  logic [atp_pkg::REG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_wdata
);
    import atp_pkg::*;

    // Rounding pipe stage contents
    typedef struct packed {
        logic             ok;
        logic [3:0]       cmd;
        logic [15:0]      ipart;
        logic [NUM_W-1:0] num;
    } s2_t;

    typedef struct packed {
        logic             ok;
        logic [3:0]       cmd;
        logic [15:0]      ipart;
        logic [NUM_W-1:0] num;
        logic [QW-1:0]    q0;
    } s3_t;

    typedef struct packed {
        logic             ok;
        logic [3:0]       cmd;
        logic [15:0]      ipart;
        logic [NUM_W-1:0] num;
        logic [QW-1:0]    q0;
        logic [PW-1:0]    prod;
    } s4_t;

    cfg_t  cfg_reg;
    msg_t  msg;
    logic  take;

    msg_t  s1_reg;
    s2_t   s2_reg;
    s3_t   s3_reg;
    s4_t   s4_reg;
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic  s1_free, s2_free, s3_free, s4_free, out_free;

    logic [31:0] ch_reg [4];
    logic [31:0] ch_next [4];
    logic        stopped_reg, stopped_next;
    out_t        res_reg, res_next;

    logic [NUM_W+RECIP_W-1:0] est_prod;
    logic [PW:0]              bound;
    logic                     round_up;
    logic [QW-1:0]            q_fix;
    logic [16:0]              upper;
    logic [31:0]              data_sat;
    logic [31:0]              data_val;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char     <= START_RESET;
            cfg_reg.delimiter_char <= DELIM_RESET;
            cfg_reg.stop_char      <= STOP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START: cfg_reg.start_char     <= cfg_wdata;
                REG_DELIM: cfg_reg.delimiter_char <= cfg_wdata;
                REG_STOP:  cfg_reg.stop_char      <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // ---------------- stall chain ----------------
    // A stage loads whenever it is empty or the stage ahead moves.
    assign out_free = !out_valid_reg || out_ready;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign in_ready = s1_free;
    assign take     = in_valid && in_ready;

    atp_byte_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_data),
        .cfg   (cfg_reg),
        .msg   (msg)
    );

    // ---------------- rounding pipe ----------------
    // frac_q16 = floor((F * 2^16 + den/2) / den), F already scaled to den.
    // q0 from a reciprocal is exact or one short; the last stage fixes it.
    assign est_prod = {{RECIP_W{1'b0}}, s2_reg.num} * {{NUM_W{1'b0}}, RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= take && in_data.end_of_message;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (s4_free)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
            s1_reg <= msg;
        if (s2_free)
        begin
            s2_reg.ok    <= s1_reg.ok;
            s2_reg.cmd   <= s1_reg.cmd;
            s2_reg.ipart <= s1_reg.ipart;
            s2_reg.num   <= {s1_reg.fpart, 16'b0} + HALF_DEN;
        end
        if (s3_free)
        begin
            s3_reg.ok    <= s2_reg.ok;
            s3_reg.cmd   <= s2_reg.cmd;
            s3_reg.ipart <= s2_reg.ipart;
            s3_reg.num   <= s2_reg.num;
            s3_reg.q0    <= est_prod[NUM_W +: QW];
        end
        if (s4_free)
        begin
            s4_reg.ok    <= s3_reg.ok;
            s4_reg.cmd   <= s3_reg.cmd;
            s4_reg.ipart <= s3_reg.ipart;
            s4_reg.num   <= s3_reg.num;
            s4_reg.q0    <= s3_reg.q0;
            s4_reg.prod  <= {{FRAC_W{1'b0}}, s3_reg.q0} * {{QW{1'b0}}, DEN};
        end
    end

    // ---------------- correction, Q16.16 assembly ----------------
    assign bound    = (PW + 1)'(s4_reg.prod) + (PW + 1)'(DEN);
    assign round_up = ((PW + 1)'(s4_reg.num) >= bound);
    assign q_fix    = s4_reg.q0 + QW'(round_up);
    assign upper    = {1'b0, s4_reg.ipart} + 17'(q_fix[QW-1:16]);
    // integer carry out means the sum passed 0xFFFFFFFF
    assign data_sat = upper[16] ? 32'hFFFF_FFFF : {upper[15:0], q_fix[15:0]};
    assign data_val = s4_reg.ok ? data_sat : 32'h0;

    // ---------------- command execution ----------------
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            ch_next[c] = ch_reg[c];
        end
        stopped_next = stopped_reg;
        if (s4_reg.ok)
        begin
            case (s4_reg.cmd) inside
                [CMD_SET_FIRST:CMD_SET_LAST]:
                begin
                    ch_next[s4_reg.cmd[1:0]] = data_val;
                    stopped_next = 1'b0;
                end
                [CMD_CLR_FIRST:CMD_CLR_LAST]:
                begin
                    ch_next[s4_reg.cmd[1:0]] = 32'h0;
                end
                CMD_STOP_ALL:
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        ch_next[c] = 32'h0;
                    end
                    stopped_next = 1'b1;
                end
                default:
                begin
                    // spare command numbers never arrive here: the parser rejects them
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.accepted      = s4_reg.ok;
        res_next.command_index = s4_reg.ok ? s4_reg.cmd : 4'h0;
        res_next.parsed_data   = data_val;
        res_next.current_ch0   = ch_next[0];
        res_next.current_ch1   = ch_next[1];
        res_next.current_ch2   = ch_next[2];
        res_next.current_ch3   = ch_next[3];
        res_next.all_stopped   = stopped_next;
    end

    // setpoints change only when a message leaves the pipe, so in order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
            begin
                ch_reg[c] <= 32'h0;
            end
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s4_valid_reg;
            if (s4_valid_reg)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    ch_reg[c] <= ch_next[c];
                end
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s4_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    // ---------------- checks ----------------
    `ASSERT_CHK(a_reject_zeroed, out_valid_reg && !res_reg.accepted |-> res_reg.command_index == 4'h0 && res_reg.parsed_data == 32'h0)
    `ASSERT_CHK(a_stop_all_clears, out_valid_reg && res_reg.accepted && res_reg.command_index == CMD_STOP_ALL |-> res_reg.all_stopped && res_reg.current_ch0 == 32'h0 && res_reg.current_ch1 == 32'h0 && res_reg.current_ch2 == 32'h0 && res_reg.current_ch3 == 32'h0)
    `ASSERT_CHK(a_s4_holds, s4_valid_reg && !out_free |=> s4_valid_reg && $stable(s4_reg))
    `ASSERT_NEVER(a_ready_when_empty, !s1_valid_reg && !in_ready)

endmodule

`default_nettype wire

[hdl/atp_byte_parser.sv]
`default_nettype none

module atp_byte_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  atp_pkg::in_t  item,
    input  atp_pkg::cfg_t cfg,
    output atp_pkg::msg_t msg
);
    import atp_pkg::*;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_CMD   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic              err_reg, err_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [15:0]       int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              point_reg, point_next;

    logic              is_digit;
    logic [3:0]        digit;
    logic [11:0]       cmd_mac;
    logic [19:0]       int_mac;
    logic [FRAC_W+3:0] frac_term;

    assign is_digit  = (item.rx_byte >= DIGIT_ZERO) && (item.rx_byte <= DIGIT_NINE);
    assign digit     = 4'(item.rx_byte - DIGIT_ZERO);
    assign cmd_mac   = {4'b0, cmd_reg} * 12'd10 + {8'b0, digit};
    assign int_mac   = {4'b0, int_reg} * 20'd10 + {16'b0, digit};
    assign frac_term = {4'b0, PLACE_WEIGHT[cnt_reg[IDX_W-1:0]]} * (FRAC_W + 4)'(digit);

    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        cmd_next   = cmd_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        point_next = point_reg;
        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (item.rx_byte == cfg.start_char)
                        phase_next = PH_CMD;
                    else
                        err_next = 1'b1;
                end
                PH_CMD:
                begin
                    if (item.rx_byte == cfg.delimiter_char)
                        phase_next = PH_DATA;
                    else if (is_digit)
                        cmd_next = (cmd_mac > 12'd255) ? 8'hFF : cmd_mac[7:0];
                    else
                        err_next = 1'b1;
                end
                PH_DATA:
                begin
                    if (item.rx_byte == cfg.stop_char)
                        phase_next = PH_DONE;
                    else if (is_digit)
                    begin
                        if (point_reg)
                        begin
                            // digits past the last place are dropped
                            if (cnt_reg < CNT_W'(FRACTION_DIGITS))
                            begin
                                frac_next = frac_reg + frac_term[FRAC_W-1:0];
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        else
                            int_next = (int_mac > 20'd65535) ? 16'hFFFF : int_mac[15:0];
                    end
                    else if (item.rx_byte == POINT_CHAR)
                        point_next = 1'b1;
                    else
                        err_next = 1'b1;
                end
                PH_DONE:
                begin
                end
            endcase
        end
    end

    // Evaluated with this byte folded in
    assign msg.ok    = !err_next && (phase_next == PH_DATA || phase_next == PH_DONE)
                       && (item.rx_byte == cfg.stop_char)
                       && (cmd_next < 8'(COMMAND_COUNT));
    assign msg.cmd   = cmd_next[3:0];
    assign msg.ipart = int_next;
    assign msg.fpart = frac_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            err_reg   <= 1'b0;
            cmd_reg   <= '0;
            int_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            point_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item.end_of_message)
            begin
                phase_reg <= PH_START;
                err_reg   <= 1'b0;
                cmd_reg   <= '0;
                int_reg   <= '0;
                frac_reg  <= '0;
                cnt_reg   <= '0;
                point_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                err_reg   <= err_next;
                cmd_reg   <= cmd_next;
                int_reg   <= int_next;
                frac_reg  <= frac_next;
                cnt_reg   <= cnt_next;
                point_reg <= point_next;
            end
        end
    end

endmodule

`default_nettype wire

[verif/tb_ascii_telecommand_parser.sv]
`timescale 1ns / 100ps

module tb_ascii_telecommand_parser;

    import atp_pkg::*;

    // Run shape
    localparam int unsigned NUM_DIRECTED  = 22;
    localparam int unsigned NUM_SEGMENTS  = 6;
    localparam int unsigned SEGMENT_BYTES = 340;   // random bytes per config setting
    localparam int unsigned DRAIN_GAP     = 16;    // pipe is 4 deep, plus margin
    localparam int unsigned LONG_HOLD     = 400;   // receiver stall, in cycles
    localparam int unsigned CYCLE_LIMIT   = 500000;

    // Parser phase as the predictor tracks it
    typedef enum logic [1:0] {
        AWAIT_START,
        IN_COMMAND,
        IN_DATA,
        AFTER_STOP
    } parse_phase_t;

    // One directed message: text is sent byte by byte, last byte flagged.
    // has_want marks rows whose report is typed in by hand.
    typedef struct {
        string text;
        bit    has_want;
        out_t  want;
    } directed_row_t;

    // DUT ports, all driven from time zero
    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_t                    in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_t                   out_data;
    logic                   cfg_write = 1'b0;
    logic [REG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_wdata = '0;

    // Predictor copy of the configuration
    logic [7:0]   start_c;
    logic [7:0]   delim_c;
    logic [7:0]   stop_c;

    // Predictor copy of the parse state and the setpoints
    parse_phase_t phase;
    logic         bad_format;
    logic [7:0]   cmd_acc;
    logic [15:0]  int_acc;
    logic [16:0]  frac_acc;
    int unsigned  frac_cnt;
    logic         point_seen;
    logic [31:0]  setpoint [4];
    logic         stopped;

    // Reports still owed by the DUT, oldest first
    out_t         pending_reports [$];

    // Bytes of the message being built
    logic [7:0]   msg_bytes [$];

    directed_row_t directed_rows [NUM_DIRECTED];
    logic [7:0]    cfg_plan [NUM_SEGMENTS][3];

    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  hold_requests = 0;   // bumped by stimulus, served by receiver
    int unsigned  holds_served  = 0;
    int unsigned  segment_bytes = 0;
    int unsigned  mismatches    = 0;
    int unsigned  cycle_count   = 0;

    ascii_telecommand_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic void clear_parse();
        phase      = AWAIT_START;
        bad_format = 1'b0;
        cmd_acc    = '0;
        int_acc    = '0;
        frac_acc   = '0;
        frac_cnt   = 0;
        point_seen = 1'b0;
    endfunction

    function automatic void reset_model();
        start_c = START_RESET;
        delim_c = DELIM_RESET;
        stop_c  = STOP_RESET;
        clear_parse();
        for (int i = 0; i < 4; i++)
        begin
            setpoint[i] = '0;
        end
        stopped = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
    endfunction

    // Integer part plus fraction rounded to nearest 1/65536, saturated
    function automatic logic [31:0] data_fixed();
        longint unsigned scale;
        longint unsigned frac;
        longint unsigned total;
        scale = 1;
        for (int unsigned i = 0; i < frac_cnt; i++)
        begin
            scale = scale * 10;
        end
        frac  = (64'(frac_acc) * 65536 + scale / 2) / scale;
        total = (64'(int_acc) << 16) + frac;
        return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    // Advance the parser by one byte request. Returns 1 with the report
    // when the byte closes a message.
    function automatic bit parse_byte(input in_t item, output out_t report);
        logic [7:0]  b;
        int unsigned v;
        bit          ok;
        b      = item.rx_byte;
        report = '0;
        if (!bad_format)
        begin
            case (phase)
                AWAIT_START:
                begin
                    if (b == start_c)
                        phase = IN_COMMAND;
                    else
                        bad_format = 1'b1;
                end
                IN_COMMAND:
                begin
                    // delimiter beats digit
                    if (b == delim_c)
                        phase = IN_DATA;
                    else if (is_digit(b))
                    begin
                        v       = cmd_acc * 10 + (b - DIGIT_ZERO);
                        cmd_acc = (v > 255) ? 8'd255 : v[7:0];
                    end
                    else
                        bad_format = 1'b1;
                end
                IN_DATA:
                begin
                    // stop beats digit, digit beats point
                    if (b == stop_c)
                        phase = AFTER_STOP;
                    else if (is_digit(b))
                    begin
                        if (point_seen)
                        begin
                            if (frac_cnt < FRACTION_DIGITS)
                            begin
                                frac_acc = 17'(frac_acc * 10 + (b - DIGIT_ZERO));
                                frac_cnt++;
                            end
                        end
                        else
                        begin
                            v       = int_acc * 10 + (b - DIGIT_ZERO);
                            int_acc = (v > 65535) ? 16'hFFFF : v[15:0];
                        end
                    end
                    else if (b == POINT_CHAR)
                        point_seen = 1'b1;
                    else
                        bad_format = 1'b1;
                end
                default: ;   // after stop: ignore until the last byte
            endcase
        end

        if (!item.end_of_message)
            return 1'b0;

        ok = !bad_format && (phase == IN_DATA || phase == AFTER_STOP) && (b == stop_c)
             && (cmd_acc < COMMAND_COUNT) && (cmd_acc < 16);
        if (ok)
        begin
            report.accepted      = 1'b1;
            report.command_index = cmd_acc[3:0];
            report.parsed_data   = data_fixed();
            if (cmd_acc <= CMD_SET_LAST)
            begin
                setpoint[cmd_acc[1:0]] = report.parsed_data;
                stopped                = 1'b0;
            end
            else if (cmd_acc <= CMD_CLR_LAST)
                setpoint[cmd_acc[1:0]] = '0;
            else if (cmd_acc == CMD_STOP_ALL)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    setpoint[i] = '0;
                end
                stopped = 1'b1;
            end
        end
        report.current_ch0 = setpoint[0];
        report.current_ch1 = setpoint[1];
        report.current_ch2 = setpoint[2];
        report.current_ch3 = setpoint[3];
        report.all_stopped = stopped;
        clear_parse();
        return 1'b1;
    endfunction

    // Hand-typed report for the directed table
    function automatic out_t make_report(input logic acc, input logic [3:0] cmd,
                                         input logic [31:0] data,
                                         input logic [31:0] c0, input logic [31:0] c1,
                                         input logic [31:0] c2, input logic [31:0] c3,
                                         input logic stp);
        out_t r;
        r.accepted      = acc;
        r.command_index = cmd;
        r.parsed_data   = data;
        r.current_ch0   = c0;
        r.current_ch1   = c1;
        r.current_ch2   = c2;
        r.current_ch3   = c3;
        r.all_stopped   = stp;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Message builders for the random part
    //------------------------------------------------------------------

    function automatic void push_number(input int unsigned value);
        logic [7:0] digits [$];
        do
        begin
            digits.push_front(8'(DIGIT_ZERO + value % 10));
            value = value / 10;
        end
        while (value != 0);
        msg_bytes = {msg_bytes, digits};
    endfunction

    function automatic void push_digits(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            msg_bytes.push_back(8'(DIGIT_ZERO + $urandom_range(9)));
        end
    endfunction

    function automatic void push_noise(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            msg_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Mostly well-formed frames with random content under the current
    // characters; the rest are corrupted, truncated or pure noise.
    function automatic void compose_message();
        int unsigned cut;
        msg_bytes.delete();
        if ($urandom_range(99) < 80)
        begin
            msg_bytes.push_back(start_c);
            case ($urandom_range(9))
                0:             ;                                   // empty command
                1, 2, 3, 4, 5, 6: push_number($urandom_range(CMD_STOP_ALL));
                7:             push_number($urandom_range(15));
                8:
                begin
                    msg_bytes.push_back(DIGIT_ZERO);               // leading zero
                    push_number($urandom_range(15));
                end
                default:       push_number($urandom_range(9999)); // overflow range
            endcase
            msg_bytes.push_back(delim_c);
            // integer part, sometimes long enough to saturate
            push_digits(($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(3));
            if ($urandom_range(9) < 6)
            begin
                msg_bytes.push_back(POINT_CHAR);
                push_digits($urandom_range(7));
                if ($urandom_range(9) == 0)
                begin
                    msg_bytes.push_back(POINT_CHAR);
                    push_digits($urandom_range(2));
                end
            end
            msg_bytes.push_back(stop_c);
            // trailing bytes after the first stop
            if ($urandom_range(9) == 0)
            begin
                push_noise($urandom_range(1, 3));
                msg_bytes.push_back(stop_c);
            end
            if ($urandom_range(9) == 0)
                msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(19) == 0)
            begin
                cut = $urandom_range(msg_bytes.size() - 1);
                while (msg_bytes.size() > cut + 1)
                begin
                    void'(msg_bytes.pop_back());
                end
            end
        end
        else
        begin
            push_noise($urandom_range(1, 8));
            if ($urandom_range(1) == 1)
                msg_bytes[msg_bytes.size() - 1] = stop_c;
        end
    endfunction

    //------------------------------------------------------------------
    // Drivers
    //------------------------------------------------------------------

    // Offer one byte request. Inputs move on the falling edge, acceptance is
    // seen at the rising edge. Valid stays up until the request is taken.
    task automatic send_request(input in_t item, input bit use_want, input out_t want);
        out_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (parse_byte(item, predicted))
            pending_reports.push_back(use_want ? want : predicted);
        segment_bytes++;
    endtask

    // Send msg_bytes as one message, end flag on the last byte
    task automatic send_message(input bit use_want, input out_t want);
        in_t item;
        for (int i = 0; i < msg_bytes.size(); i++)
        begin
            item.rx_byte        = msg_bytes[i];
            item.end_of_message = (i == msg_bytes.size() - 1);
            send_request(item, use_want, want);
        end
    endtask

    // Drop valid, then wait for every owed report plus the pipe depth
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_register(input logic [REG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_START: start_c = value;
            REG_DELIM: delim_c = value;
            REG_STOP:  stop_c  = value;
            default:   ;
        endcase
    endtask

    //------------------------------------------------------------------
    // Report checker
    //------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report: expected none, actual %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                out_t want;
                want = pending_reports.pop_front();
                check_field("accepted",      32'(want.accepted),      32'(out_data.accepted));
                check_field("command_index", 32'(want.command_index),
                            32'(out_data.command_index));
                check_field("parsed_data",   want.parsed_data,        out_data.parsed_data);
                check_field("current_ch0",   want.current_ch0,        out_data.current_ch0);
                check_field("current_ch1",   want.current_ch1,        out_data.current_ch1);
                check_field("current_ch2",   want.current_ch2,        out_data.current_ch2);
                check_field("current_ch3",   want.current_ch3,        out_data.current_ch3);
                check_field("all_stopped",   32'(want.all_stopped),   32'(out_data.all_stopped));
            end
        end
    end

    //------------------------------------------------------------------
    // Clock, receiver, watchdog
    //------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long stall on request from
    // the stimulus so the pipe fills and in_ready drops.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------

    initial
    begin
        bit paused_once;
        bit held_once;

        // Directed messages under the reset characters. Hand-typed reports
        // only where the state is obvious: right after reset, the Q16.16
        // ceiling, stop-all and rejects that follow it.
        directed_rows = '{
            '{"X",                    1'b1, make_report(1'b0, 4'h0, 32'h0, 32'h0, 32'h0,
                                                        32'h0, 32'h0, 1'b0)},
            '{"$0,1#",                1'b1, make_report(1'b1, 4'h0, 32'h0001_0000,
                                                        32'h0001_0000, 32'h0, 32'h0,
                                                        32'h0, 1'b0)},
            '{"$1,65535.99999#",      1'b1, make_report(1'b1, 4'h1, 32'hFFFF_FFFF,
                                                        32'h0001_0000, 32'hFFFF_FFFF,
                                                        32'h0, 32'h0, 1'b0)},
            '{"$2,99999999.1234567#", 1'b0, '0},   // integer saturates, 6th+ digit dropped
            '{"$3,.5#",               1'b0, '0},   // fraction only
            '{"$2,1.2.3#",            1'b0, '0},   // repeated points
            '{"$5,#",                 1'b0, '0},   // clear ch1, empty data
            '{"$4,9#",                1'b0, '0},   // clear ch0, data still reported
            '{"$,7#",                 1'b0, '0},   // empty command is command 0
            '{"$6,#",                 1'b0, '0},
            '{"$7,#",                 1'b0, '0},
            '{"$8,#",                 1'b1, make_report(1'b1, CMD_STOP_ALL, 32'h0, 32'h0,
                                                        32'h0, 32'h0, 32'h0, 1'b1)},
            '{"$9,1#",                1'b1, make_report(1'b0, 4'h0, 32'h0, 32'h0, 32'h0,
                                                        32'h0, 32'h0, 1'b1)},
            '{"$300,1#",              1'b1, make_report(1'b0, 4'h0, 32'h0, 32'h0, 32'h0,
                                                        32'h0, 32'h0, 1'b1)},
            '{"$00000000001,2#",      1'b0, '0},   // leading zeros, clears stopped
            '{"$1,2",                 1'b0, '0},   // last byte not stop
            '{"$12",                  1'b0, '0},   // no delimiter
            '{"$1,2#zz#",             1'b0, '0},   // junk after stop ignored
            '{"$1,2#zz",              1'b0, '0},
            '{"$3,1x#",               1'b0, '0},   // bad data byte
            '{"$3,1,2#",              1'b0, '0},   // second delimiter is bad data
            '{"$1#",                  1'b0, '0}    // stop inside command digits
        };

        // (start, delimiter, stop) per random segment: reset values, the
        // byte extremes, start equal to delimiter with stop on the point,
        // and delimiter and stop colliding with digits.
        cfg_plan = '{
            '{8'd36,  8'd44,  8'd35},
            '{8'd0,   8'd255, 8'd0},
            '{8'd255, 8'd0,   8'd255},
            '{8'd44,  8'd44,  8'd46},
            '{8'd36,  8'd53,  8'd57},
            '{8'd36,  8'd44,  8'd35}
        };

        paused_once = 1'b0;
        held_once   = 1'b0;
        reset_model();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 74;
        foreach (directed_rows[r])
        begin
            msg_bytes.delete();
            for (int k = 0; k < directed_rows[r].text.len(); k++)
            begin
                msg_bytes.push_back(directed_rows[r].text[k]);
            end
            send_message(directed_rows[r].has_want, directed_rows[r].want);
        end
        wait_drained();

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            // idle pattern: sender light / receiver heavy, swapped, then none
            if (seg < 2)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 74;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // block is idle here: every message closed and drained
            write_register(REG_START, cfg_plan[seg][0]);
            write_register(REG_DELIM, cfg_plan[seg][1]);
            write_register(REG_STOP,  cfg_plan[seg][2]);

            segment_bytes = 0;
            while (segment_bytes < SEGMENT_BYTES)
            begin
                compose_message();
                send_message(1'b0, '0);
                // sender stops until every owed report is back
                if (seg == 1 && !paused_once && segment_bytes >= SEGMENT_BYTES / 2)
                begin
                    wait_drained();
                    paused_once = 1'b1;
                end
                // long receiver stall while requests keep coming
                if (seg == 4 && !held_once && segment_bytes >= 100)
                begin
                    hold_requests++;
                    held_once = 1'b1;
                end
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/atp_pkg.sv
hdl/atp_byte_parser.sv
hdl/ascii_telecommand_parser.sv
verif/tb_ascii_telecommand_parser.sv
